// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

  localparam int NCORNER = 8;

  // per corner: bit0 x negative, bit1 y negative, bit2 z negative
  localparam logic [2:0] CORNER_NEG [NCORNER] = '{
    3'b000, 3'b010, 3'b110, 3'b100, 3'b001, 3'b011, 3'b111, 3'b101
  };

  localparam logic [2:0] CFG_PP_X = 3'd0;
  localparam logic [2:0] CFG_PP_Y = 3'd1;
  localparam logic [2:0] CFG_PP_Z = 3'd2;
  localparam logic [2:0] CFG_N_X  = 3'd3;
  localparam logic [2:0] CFG_N_Y  = 3'd4;
  localparam logic [2:0] CFG_N_Z  = 3'd5;

  localparam logic signed [15:0] Q14_ONE = 16'sd16384;
  localparam logic signed [31:0] Q28_ONE = 32'sd268435456;

  localparam int IN_W  = 288;
  localparam int OUT_W = 160;

  typedef logic signed [35:0] corner_t;  // corner coordinate, Q16.16
  typedef logic signed [42:0] dist16_t;  // rounded distance, Q16.16

  function automatic logic signed [15:0] clamp_q14(input logic signed [15:0] v);
    logic signed [15:0] res;
    res = v;
    if (v > Q14_ONE) res = Q14_ONE;
    if (v < -Q14_ONE) res = -Q14_ONE;
    return res;
  endfunction

endpackage

// ----- rtl/box_plane_contacts_top.sv -----
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready     | in_tdata: box (ids, centre, quaternion, size)
// out_    | out | out_tvalid / out_tready   | out_tdata, out_tuser (hit), out_tlast
// cfg_    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data: plane point and normal
// a box passes seven arithmetic stages, a corner holder and three output stages
// between its input word and its first result word.
// the corner holder sends one result per cycle while p1 can take it, so a box holds it for
// 1 to CONTACT_CAP results; boxes with one result flow one per cycle when nothing stalls.
// rst_n clears valid bits and loads the plane registers; payload registers are not reset.
// every stage advances only when the stage after it can take its word; nothing is lost
// or repeated while out_tready is low.
module box_plane_contacts_top #(
  parameter int CONTACT_CAP = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // body_id, plane_id, box_pos_x/y/z, rot_w/x/y/z, size_x/y/z, zero fill
  input  logic [bpc_pkg::IN_W-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // out_body_id, out_plane_id, contact_x/y/z, depth, zero fill
  output logic [bpc_pkg::OUT_W-1:0] out_tdata,
  // hit
  output logic                     out_tuser,
  output logic                     out_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data
);

  localparam int CW = $clog2(CONTACT_CAP + 1);

  // plane registers
  logic signed [31:0] pp_r [3];
  logic signed [15:0] nraw_r [3];
  logic signed [15:0] n [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r[0] <= '0;
      pp_r[1] <= '0;
      pp_r[2] <= '0;
      nraw_r[0] <= '0;
      nraw_r[1] <= bpc_pkg::Q14_ONE;
      nraw_r[2] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpc_pkg::CFG_PP_X: pp_r[0] <= cfg_data;
        bpc_pkg::CFG_PP_Y: pp_r[1] <= cfg_data;
        bpc_pkg::CFG_PP_Z: pp_r[2] <= cfg_data;
        bpc_pkg::CFG_N_X:  nraw_r[0] <= cfg_data[15:0];
        bpc_pkg::CFG_N_Y:  nraw_r[1] <= cfg_data[15:0];
        bpc_pkg::CFG_N_Z:  nraw_r[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) n[a] = bpc_pkg::clamp_q14(nraw_r[a]);
  end

  // stage valid bits and ready chain
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, v_g_r, h_v_r, v_p1_r, v_p2_r, v_p3_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_p1, rdy_p2, rdy_p3;
  logic h_emit, h_last, h_free;

  assign rdy_p3 = !v_p3_r || out_tready;
  assign rdy_p2 = !v_p2_r || rdy_p3;
  assign rdy_p1 = !v_p1_r || rdy_p2;
  assign h_emit = h_v_r && rdy_p1;
  assign h_free = !h_v_r || (h_emit && h_last);
  assign rdy_g  = !v_g_r || h_free;
  assign rdy_f  = !v_f_r || rdy_g;
  assign rdy_e  = !v_e_r || rdy_f;
  assign rdy_d  = !v_d_r || rdy_e;
  assign rdy_c  = !v_c_r || rdy_d;
  assign rdy_b  = !v_b_r || rdy_c;
  assign rdy_a  = !v_a_r || rdy_b;
  assign in_tready = rdy_a;

  // ids travel with every stage
  logic [31:0] id_a_r, id_b_r, id_c_r, id_d_r, id_e_r, id_f_r, id_g_r, id_h_r, id_p1_r,
               id_p2_r, id_p3_r;

  // stage a: unpack and clamp
  logic signed [31:0] pos_a_r [3];
  logic [30:0]        e_a_r [3];
  logic signed [15:0] q_a_r [4];

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      id_a_r <= in_tdata[31:0];
      pos_a_r[0] <= in_tdata[63:32];
      pos_a_r[1] <= in_tdata[95:64];
      pos_a_r[2] <= in_tdata[127:96];
      q_a_r[0] <= bpc_pkg::clamp_q14(in_tdata[143:128]);
      q_a_r[1] <= bpc_pkg::clamp_q14(in_tdata[159:144]);
      q_a_r[2] <= bpc_pkg::clamp_q14(in_tdata[175:160]);
      q_a_r[3] <= bpc_pkg::clamp_q14(in_tdata[191:176]);
      e_a_r[0] <= in_tdata[222:192];
      e_a_r[1] <= in_tdata[253:223];
      e_a_r[2] <= in_tdata[284:254];
    end
  end

  // stage b: rotation matrix, Q2.28
  logic signed [31:0] pos_b_r [3];
  logic [30:0]        e_b_r [3];
  logic signed [31:0] r_b_r [3][3];
  logic signed [31:0] r_nxt [3][3];
  logic signed [31:0] qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;

  always_comb begin
    qxx = q_a_r[1] * q_a_r[1];
    qyy = q_a_r[2] * q_a_r[2];
    qzz = q_a_r[3] * q_a_r[3];
    qxy = q_a_r[1] * q_a_r[2];
    qxz = q_a_r[1] * q_a_r[3];
    qyz = q_a_r[2] * q_a_r[3];
    qwx = q_a_r[0] * q_a_r[1];
    qwy = q_a_r[0] * q_a_r[2];
    qwz = q_a_r[0] * q_a_r[3];
    r_nxt[0][0] = bpc_pkg::Q28_ONE - ((qyy + qzz) <<< 1);
    r_nxt[0][1] = (qxy - qwz) <<< 1;
    r_nxt[0][2] = (qxz + qwy) <<< 1;
    r_nxt[1][0] = (qxy + qwz) <<< 1;
    r_nxt[1][1] = bpc_pkg::Q28_ONE - ((qxx + qzz) <<< 1);
    r_nxt[1][2] = (qyz - qwx) <<< 1;
    r_nxt[2][0] = (qxz - qwy) <<< 1;
    r_nxt[2][1] = (qyz + qwx) <<< 1;
    r_nxt[2][2] = bpc_pkg::Q28_ONE - ((qxx + qyy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      id_b_r <= id_a_r;
      pos_b_r <= pos_a_r;
      e_b_r <= e_a_r;
      r_b_r <= r_nxt;
    end
  end

  // stage c: r times half extent, Q.45
  logic signed [31:0] pos_c_r [3];
  logic signed [63:0] p_c_r [3][3];

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      id_c_r <= id_b_r;
      pos_c_r <= pos_b_r;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          p_c_r[a][b] <= 64'(r_b_r[a][b] * $signed({1'b0, e_b_r[b]}));
    end
  end

  // stage d: round both signs of each term to Q16.16
  logic signed [31:0] pos_d_r [3];
  logic signed [34:0] tp_d_r [3][3];
  logic signed [34:0] tn_d_r [3][3];
  logic signed [63:0] tp_nxt [3][3];
  logic signed [63:0] tn_nxt [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        tp_nxt[a][b] = (p_c_r[a][b] + 64'sd268435456) >>> 29;
        tn_nxt[a][b] = (64'sd268435456 - p_c_r[a][b]) >>> 29;
      end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      id_d_r <= id_c_r;
      pos_d_r <= pos_c_r;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) begin
          tp_d_r[a][b] <= tp_nxt[a][b][34:0];
          tn_d_r[a][b] <= tn_nxt[a][b][34:0];
        end
    end
  end

  // stage e: eight corners
  bpc_pkg::corner_t c_e_r [bpc_pkg::NCORNER][3];
  bpc_pkg::corner_t c_nxt [bpc_pkg::NCORNER][3];

  always_comb begin
    for (int i = 0; i < bpc_pkg::NCORNER; i++)
      for (int a = 0; a < 3; a++) begin
        c_nxt[i][a] = 36'(pos_d_r[a]);
        for (int b = 0; b < 3; b++)
          c_nxt[i][a] = c_nxt[i][a] + 36'(bpc_pkg::CORNER_NEG[i][b] ? tn_d_r[a][b]
                                                                    : tp_d_r[a][b]);
      end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      id_e_r <= id_d_r;
      c_e_r <= c_nxt;
    end
  end

  // stage f: per axis distance products, Q.30
  bpc_pkg::corner_t   c_f_r [bpc_pkg::NCORNER][3];
  logic signed [52:0] dp_f_r [bpc_pkg::NCORNER][3];

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      id_f_r <= id_e_r;
      c_f_r <= c_e_r;
      for (int i = 0; i < bpc_pkg::NCORNER; i++)
        for (int a = 0; a < 3; a++)
          dp_f_r[i][a] <= 53'((37'(c_e_r[i][a]) - 37'(pp_r[a])) * n[a]);
    end
  end

  // stage g: distance sum, touch flags, rounded distance
  bpc_pkg::corner_t  c_g_r [bpc_pkg::NCORNER][3];
  bpc_pkg::dist16_t  d16_g_r [bpc_pkg::NCORNER];
  logic [bpc_pkg::NCORNER-1:0] touch_g_r;
  logic signed [54:0] dsum [bpc_pkg::NCORNER];
  logic signed [54:0] dr [bpc_pkg::NCORNER];

  always_comb begin
    for (int i = 0; i < bpc_pkg::NCORNER; i++) begin
      dsum[i] = 55'(dp_f_r[i][0]) + 55'(dp_f_r[i][1]) + 55'(dp_f_r[i][2]);
      dr[i] = (dsum[i] + 55'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_g) begin
      id_g_r <= id_f_r;
      c_g_r <= c_f_r;
      for (int i = 0; i < bpc_pkg::NCORNER; i++) begin
        d16_g_r[i] <= dr[i][42:0];
        touch_g_r[i] <= (dsum[i] <= 55'sd0);
      end
    end
  end

  // corner holder: one result per cycle while p1 can take it
  bpc_pkg::corner_t  c_h_r [bpc_pkg::NCORNER][3];
  bpc_pkg::dist16_t  d16_h_r [bpc_pkg::NCORNER];
  logic [bpc_pkg::NCORNER-1:0] mask_h_r, mask_rest;
  logic              none_h_r;
  logic [CW-1:0]     cnt_h_r;
  logic [2:0]        sel;

  always_comb begin
    sel = '0;
    for (int i = bpc_pkg::NCORNER - 1; i >= 0; i--)
      if (mask_h_r[i]) sel = 3'(i);
    mask_rest = mask_h_r;
    mask_rest[sel] = 1'b0;
    h_last = none_h_r || (mask_rest == '0) || (cnt_h_r == CW'(CONTACT_CAP - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (h_free) begin
      h_v_r <= v_g_r;
    end
    if (h_free) begin
      id_h_r <= id_g_r;
      c_h_r <= c_g_r;
      d16_h_r <= d16_g_r;
      mask_h_r <= touch_g_r;
      none_h_r <= (touch_g_r == '0);
      cnt_h_r <= '0;
    end else if (h_emit) begin
      mask_h_r <= mask_rest;
      cnt_h_r <= cnt_h_r + 1'b1;
    end
  end

  // p1: selected corner
  bpc_pkg::corner_t c_p1_r [3];
  bpc_pkg::dist16_t d16_p1_r;
  logic hit_p1_r, last_p1_r;

  always_ff @(posedge clk) begin
    if (rdy_p1) begin
      id_p1_r <= id_h_r;
      for (int a = 0; a < 3; a++) c_p1_r[a] <= c_h_r[sel][a];
      d16_p1_r <= d16_h_r[sel];
      hit_p1_r <= !none_h_r;
      last_p1_r <= h_last;
    end
  end

  // p2: push products
  bpc_pkg::corner_t c_p2_r [3];
  bpc_pkg::dist16_t d16_p2_r;
  logic signed [59:0] push_p2_r [3];
  logic hit_p2_r, last_p2_r;

  always_ff @(posedge clk) begin
    if (rdy_p2) begin
      id_p2_r <= id_p1_r;
      c_p2_r <= c_p1_r;
      d16_p2_r <= d16_p1_r;
      hit_p2_r <= hit_p1_r;
      last_p2_r <= last_p1_r;
      for (int a = 0; a < 3; a++) push_p2_r[a] <= 60'(d16_p1_r * n[a]);
    end
  end

  // p3: subtract, saturate, output word
  logic signed [59:0] rp [3];
  logic signed [60:0] pt [3];
  logic signed [31:0] pt_sat [3];
  logic signed [43:0] dep;
  logic [30:0]        dep_sat;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        depth_r;
  logic               hit_r, last_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rp[a] = (push_p2_r[a] + 60'sd16384) >>> 15;
      pt[a] = 61'(c_p2_r[a]) - 61'(rp[a]);
      if (pt[a] > 61'sd2147483647) pt_sat[a] = 32'sh7FFFFFFF;
      else if (pt[a] < -61'sd2147483648) pt_sat[a] = 32'sh80000000;
      else pt_sat[a] = pt[a][31:0];
      if (!hit_p2_r) pt_sat[a] = '0;
    end
    dep = -44'(d16_p2_r);
    if (dep < 44'sd0) dep_sat = '0;
    else if (dep > 44'sd2147483647) dep_sat = 31'h7FFFFFFF;
    else dep_sat = dep[30:0];
    if (!hit_p2_r) dep_sat = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy_p3) begin
      id_p3_r <= id_p2_r;
      cx_r <= pt_sat[0];
      cy_r <= pt_sat[1];
      cz_r <= pt_sat[2];
      depth_r <= dep_sat;
      hit_r <= hit_p2_r;
      last_r <= last_p2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
      v_g_r <= 1'b0;
      v_p1_r <= 1'b0;
      v_p2_r <= 1'b0;
      v_p3_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r <= in_tvalid;
      if (rdy_b) v_b_r <= v_a_r;
      if (rdy_c) v_c_r <= v_b_r;
      if (rdy_d) v_d_r <= v_c_r;
      if (rdy_e) v_e_r <= v_d_r;
      if (rdy_f) v_f_r <= v_e_r;
      if (rdy_g) v_g_r <= v_f_r;
      if (rdy_p1) v_p1_r <= h_v_r;
      if (rdy_p2) v_p2_r <= v_p1_r;
      if (rdy_p3) v_p3_r <= v_p2_r;
    end
  end

  assign out_tvalid = v_p3_r;
  assign out_tdata = {1'b0, depth_r, cz_r, cy_r, cx_r, id_p3_r};
  assign out_tuser = hit_r;
  assign out_tlast = last_r;

endmodule

// ----- dv/contact_checker.sv -----
`timescale 1ns / 1ps

module contact_checker #(
  parameter int CONTACT_CAP = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [bpc_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [bpc_pkg::OUT_W-1:0] out_tdata,
  input  logic                      out_tuser,
  input  logic                      out_tlast,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output int                        fails,
  output int                        pending,
  output int                        boxes_seen,
  output int                        contacts_seen,
  output int                        misses_seen
);

  typedef struct packed {
    logic [15:0] body_id;
    logic [15:0] plane_id;
    logic        hit;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] depth;
    logic        last;
  } contact_t;

  contact_t contacts_due[$];

  logic signed [31:0] plane_pt [3];
  logic signed [15:0] plane_n [3];

  function automatic longint sat_unit(input logic signed [15:0] v);
    longint x;
    x = longint'(v);
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    return x;
  endfunction

  function automatic logic [31:0] sat_word(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // corners of one box against the current plane
  task automatic predict_contacts(input logic [bpc_pkg::IN_W-1:0] d);
    longint pos[3], ext[3], pp[3], nn[3], r[3][3], c[3];
    longint qw, qx, qy, qz, dsum, d16, ev, dep;
    contact_t ct;
    int count;
    count = 0;
    pos[0] = longint'(signed'(d[63:32]));
    pos[1] = longint'(signed'(d[95:64]));
    pos[2] = longint'(signed'(d[127:96]));
    ext[0] = longint'({1'b0, d[222:192]});
    ext[1] = longint'({1'b0, d[253:223]});
    ext[2] = longint'({1'b0, d[284:254]});
    qw = sat_unit(d[143:128]);
    qx = sat_unit(d[159:144]);
    qy = sat_unit(d[175:160]);
    qz = sat_unit(d[191:176]);
    for (int a = 0; a < 3; a++) begin
      pp[a] = longint'(plane_pt[a]);
      nn[a] = sat_unit(plane_n[a]);
    end
    r[0][0] = 64'sd268435456 - 2 * (qy * qy + qz * qz);
    r[0][1] = 2 * (qx * qy - qw * qz);
    r[0][2] = 2 * (qx * qz + qw * qy);
    r[1][0] = 2 * (qx * qy + qw * qz);
    r[1][1] = 64'sd268435456 - 2 * (qx * qx + qz * qz);
    r[1][2] = 2 * (qy * qz - qw * qx);
    r[2][0] = 2 * (qx * qz - qw * qy);
    r[2][1] = 2 * (qy * qz + qw * qx);
    r[2][2] = 64'sd268435456 - 2 * (qx * qx + qy * qy);
    ct.body_id = d[15:0];
    ct.plane_id = d[31:16];
    for (int i = 0; i < bpc_pkg::NCORNER && count < CONTACT_CAP; i++) begin
      dsum = 0;
      for (int a = 0; a < 3; a++) begin
        c[a] = pos[a];
        for (int b = 0; b < 3; b++) begin
          ev = bpc_pkg::CORNER_NEG[i][b] ? -ext[b] : ext[b];
          c[a] += (r[a][b] * ev + 64'sd268435456) >>> 29;
        end
        dsum += (c[a] - pp[a]) * nn[a];
      end
      if (dsum <= 0) begin
        d16 = (dsum + 8192) >>> 14;
        ct.hit = 1'b1;
        ct.cx = sat_word(c[0] - ((d16 * nn[0] + 16384) >>> 15));
        ct.cy = sat_word(c[1] - ((d16 * nn[1] + 16384) >>> 15));
        ct.cz = sat_word(c[2] - ((d16 * nn[2] + 16384) >>> 15));
        dep = -d16;
        if (dep < 0) dep = 0;
        if (dep > 64'sd2147483647) dep = 64'sd2147483647;
        ct.depth = dep[30:0];
        ct.last = 1'b0;
        contacts_due.push_back(ct);
        count++;
      end
    end
    if (count == 0) begin
      ct.hit = 1'b0;
      ct.cx = '0;
      ct.cy = '0;
      ct.cz = '0;
      ct.depth = '0;
      ct.last = 1'b1;
      contacts_due.push_back(ct);
    end else begin
      contacts_due[$].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    contact_t want, got;
    if (!rst_n) begin
      plane_pt[0] <= '0;
      plane_pt[1] <= '0;
      plane_pt[2] <= '0;
      plane_n[0] <= '0;
      plane_n[1] <= bpc_pkg::Q14_ONE;
      plane_n[2] <= '0;
      contacts_due.delete();
      fails <= 0;
      boxes_seen <= 0;
      contacts_seen <= 0;
      misses_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpc_pkg::CFG_PP_X: plane_pt[0] <= cfg_data;
          bpc_pkg::CFG_PP_Y: plane_pt[1] <= cfg_data;
          bpc_pkg::CFG_PP_Z: plane_pt[2] <= cfg_data;
          bpc_pkg::CFG_N_X:  plane_n[0] <= cfg_data[15:0];
          bpc_pkg::CFG_N_Y:  plane_n[1] <= cfg_data[15:0];
          bpc_pkg::CFG_N_Z:  plane_n[2] <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_contacts(in_tdata);
        boxes_seen <= boxes_seen + 1;
      end
      if (out_tvalid && out_tready) begin
        got.body_id = out_tdata[15:0];
        got.plane_id = out_tdata[31:16];
        got.hit = out_tuser;
        got.cx = out_tdata[63:32];
        got.cy = out_tdata[95:64];
        got.cz = out_tdata[127:96];
        got.depth = out_tdata[158:128];
        got.last = out_tlast;
        if (got.hit) contacts_seen <= contacts_seen + 1;
        else misses_seen <= misses_seen + 1;
        if (contacts_due.size() == 0) begin
          $display("%0t: unexpected word, got %p", $realtime, got);
          fails <= fails + 1;
        end else begin
          want = contacts_due.pop_front();
          if (got !== want || out_tdata[159] !== 1'b0) begin
            $display("%0t: mismatch, expected %p", $realtime, want);
            $display("%0t:           got      %p", $realtime, got);
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= contacts_due.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 5000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [bpc_pkg::IN_W-1:0]    in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [bpc_pkg::OUT_W-1:0]   out_tdata;
  logic                        out_tuser;
  logic                        out_tlast;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [2:0]                  cfg_index;
  logic [31:0]                 cfg_data;

  int fails, pending, boxes_seen, contacts_seen, misses_seen;
  int boxes_sent;
  int idle_cycles;
  logic signed [31:0] cur_pt [3];

  box_plane_contacts_top i_dut (.*);

  contact_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: own stall pattern, one long hold-off once 120 boxes have been sent
  initial begin
    int hold;
    bit held;
    held = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && boxes_sent >= 120) begin
        held = 1;
        out_tready = 1'b0;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
      end
      case ((boxes_sent / 40) % 3)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(3) != 0);
        default: out_tready = ($urandom_range(1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_box(input logic [bpc_pkg::IN_W-1:0] d);
    @(negedge clk);
    in_tdata = d;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    boxes_sent++;
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == bpc_pkg::CFG_PP_X) cur_pt[0] = val;
    if (idx == bpc_pkg::CFG_PP_Y) cur_pt[1] = val;
    if (idx == bpc_pkg::CFG_PP_Z) cur_pt[2] = val;
  endtask

  // wait for the pipe to drain before touching the plane
  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [bpc_pkg::IN_W-1:0] box_word(
      input logic [15:0] bid, input logic [15:0] pid,
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [15:0] qw, input logic [15:0] qx, input logic [15:0] qy,
      input logic [15:0] qz,
      input logic [30:0] sx, input logic [30:0] sy, input logic [30:0] sz);
    return {3'b000, sz, sy, sx, qz, qy, qx, qw, pz, py, px, pid, bid};
  endfunction

  function automatic logic [15:0] rand_unit;
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom());
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  function automatic logic [bpc_pkg::IN_W-1:0] rand_box;
    logic [31:0] p [3];
    logic [30:0] s [3];
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(9) < 7) begin
        // close to the plane point so that corners touch often
        p[a] = cur_pt[a] + 32'($urandom_range(32'h00400000)) - 32'h00200000;
        s[a] = 31'($urandom_range(32'h00400000));
      end else begin
        p[a] = $urandom();
        s[a] = 31'($urandom());
      end
    end
    return box_word(16'($urandom()), 16'($urandom()), p[0], p[1], p[2],
                    rand_unit(), rand_unit(), rand_unit(), rand_unit(), s[0], s[1], s[2]);
  endfunction

  task automatic random_run(input int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_box(rand_box());
        left--;
        if (boxes_sent == 260) begin
          // stop offering until every contact is out
          pause(1);
          wait (pending == 0);
        end
      end
      if ($urandom_range(3) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    localparam logic [15:0] Q1 = 16'sd16384;
    localparam logic [15:0] QN = -16'sd16384;
    localparam logic [30:0] S1 = 31'h00020000;
    boxes_sent = 0;
    cur_pt = '{default: '0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = bpc_pkg::CFG_PP_X;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, default floor plane y = 0
    send_box(box_word(16'h0000, 16'h0000, 0, 0, 0, Q1, 0, 0, 0, 0, 0, 0));
    send_box(box_word(16'hffff, 16'hffff, 0, 32'h00100000, 0, Q1, 0, 0, 0, S1, S1, S1));
    send_box(box_word(16'h1234, 16'h0001, 0, 32'hfff00000, 0, Q1, 0, 0, 0, S1, S1, S1));
    send_box(box_word(16'h0002, 16'h0002, 0, 32'h00008000, 0, Q1, 0, 0, 0, S1, S1, S1));
    send_box(box_word(16'h0003, 16'h0003, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      Q1, 0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_box(box_word(16'h0004, 16'h0004, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      QN, QN, QN, QN, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_box(box_word(16'h0005, 16'h0005, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                      S1, S1, S1));
    send_box(box_word(16'h0006, 16'h0006, 0, 32'h00010000, 0, 16'sd11585, 16'sd11585,
                      0, 0, S1, 31'h00040000, S1));
    send_box(box_word(16'h0007, 16'h0007, 0, 0, 0, 0, 0, 0, Q1, S1, S1, S1));
    send_box(box_word(16'h0008, 16'h0008, 0, 0, 0, 0, 0, 0, 0, S1, S1, S1));
    send_box(box_word(16'h0009, 16'h0009, 0, 32'h00010001, 0, Q1, 0, 0, 0, S1, S1, S1));
    pause(1);
    random_run(120);
    drain();

    // random plane
    write_reg(bpc_pkg::CFG_PP_X, $urandom());
    write_reg(bpc_pkg::CFG_PP_Y, $urandom());
    write_reg(bpc_pkg::CFG_PP_Z, $urandom());
    write_reg(bpc_pkg::CFG_N_X, 32'(signed'(rand_unit())));
    write_reg(bpc_pkg::CFG_N_Y, 32'(signed'(rand_unit())));
    write_reg(bpc_pkg::CFG_N_Z, 32'(signed'(rand_unit())));
    write_reg(3'd6, $urandom());
    write_reg(3'd7, $urandom());
    random_run(180);
    drain();

    // extreme plane: corner point, out of range normal parts
    write_reg(bpc_pkg::CFG_PP_X, 32'h7fffffff);
    write_reg(bpc_pkg::CFG_PP_Y, 32'h80000000);
    write_reg(bpc_pkg::CFG_PP_Z, 32'h7fffffff);
    write_reg(bpc_pkg::CFG_N_X, 32'h00007fff);
    write_reg(bpc_pkg::CFG_N_Y, 32'hffff8000);
    write_reg(bpc_pkg::CFG_N_Z, 32'hffffc000);
    send_box(box_word(16'h00aa, 16'h0055, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      Q1, 0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    random_run(100);
    drain();

    // tilted plane through the origin
    write_reg(bpc_pkg::CFG_PP_X, 0);
    write_reg(bpc_pkg::CFG_PP_Y, 0);
    write_reg(bpc_pkg::CFG_PP_Z, 0);
    write_reg(bpc_pkg::CFG_N_X, 32'sd9459);
    write_reg(bpc_pkg::CFG_N_Y, 32'sd9459);
    write_reg(bpc_pkg::CFG_N_Z, -32'sd9459);
    random_run(100);

    pause(1);
    wait (pending == 0);
    repeat (30) @(posedge clk);
    $display("run covered %0d boxes over four plane settings: %0d contacts, %0d misses",
             boxes_seen, contacts_seen, misses_seen);
    $display("including a long output hold-off and a full drain mid-stream");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fails);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
